// File: rtl/core/prq_pkg.sv
// prq_pkg: sizes, operation codes and shared types of the priority ready queue scheduler.
// No dependencies; every other file of the block imports it.
`default_nettype none

package prq_pkg;

  // Queue geometry
  localparam int LEVELS = 8;
  localparam int TASKS  = 16;

  // Field widths of the channel words
  localparam int KIND_W = 2;
  localparam int TID_W  = 5;
  localparam int PRI_W  = 3;

  // Derived storage widths
  localparam int IDX_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CNT_W   = $clog2(TASKS + 1);
  localparam int SUM_W   = $clog2(2 * TASKS);
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEPTH   = LEVELS * TASKS;
  localparam int ADDR_W  = $clog2(DEPTH);

  // Operation codes of the kind field
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  // Request from the sequencer to the queue store
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// File: rtl/core/prq_in_if.sv
// prq_in_if: request channel (valid/ready plus one request word).
// Depends on prq_pkg for field widths.
`default_nettype none

interface prq_in_if
  import prq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  task_id;
  logic [PRI_W-1:0]  priority_req;

  modport source (output valid, output kind, output task_id, output priority_req,
                  input ready);
  modport sink   (input valid, input kind, input task_id, input priority_req,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/prq_out_if.sv
// prq_out_if: response channel (valid/ready plus one response word).
// Depends on prq_pkg for field widths.
`default_nettype none

interface prq_out_if
  import prq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [TID_W-1:0] result_task;
  logic             found;
  logic             overflow;

  modport source (output valid, output result_task, output found, output overflow,
                  input ready);
  modport sink   (input valid, input result_task, input found, input overflow,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/priority_ready_queue_scheduler.sv
// priority_ready_queue_scheduler: one ring FIFO of task ids per priority level.
// Depends on prq_pkg, prq_in_if, prq_out_if, prq_mod_add and prq_store.
//
//   channel | dir | handshake    | word
//   --------+-----+--------------+------------------------------------
//   req     | in  | valid/ready  | kind, task_id, priority_req
//   rsp     | out | valid/ready  | result_task, found, overflow
//
// Each word is handled in S_IDLE, then S_FINISH: the accept edge does the level search,
// the pointer add in the shared adder and the store write or read; S_FINISH then loads
// the response register and stalls while the response register is still full.
// Reset clears heads and counts; the entry store is not cleared.
// req.ready is high only while the sequencer is idle.
`default_nettype none

module priority_ready_queue_scheduler
  import prq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  prq_in_if.sink    req,
  prq_out_if.source rsp
);

  typedef enum logic {S_IDLE, S_FINISH} state_t;

  state_t           state;
  logic [IDX_W-1:0] head [LEVELS];
  logic [CNT_W-1:0] cnt  [LEVELS];

  // latched outcome of the accepted word
  logic hit;
  logic ovf;
  logic empty_pop;

  logic             accept;
  logic [LEVELS-1:0] busy_vec;
  logic             any_busy;
  logic [LVL_W-1:0] first_lvl;
  logic [LVL_W-1:0] lvl_sel;
  logic [IDX_W-1:0] head_sel;
  logic [CNT_W-1:0] cnt_sel;
  logic             push_ok;
  logic             push_full;
  logic             push_do;
  logic             pop_do;
  logic             look_do;
  logic [CNT_W-1:0] add_b;
  logic [IDX_W-1:0] add_sum;
  logic [IDX_W-1:0] slot;
  mem_req_t         mreq;
  logic [IDX_W-1:0] rd_data;
  logic             rsp_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;

  // highest-priority non-empty level
  always_comb begin
    first_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      busy_vec[l] = (cnt[l] != '0);
    end
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (busy_vec[l]) begin
        first_lvl = LVL_W'(l);
      end
    end
    any_busy = |busy_vec;
  end

  // decode the request word
  always_comb begin
    push_ok = 1'b0;
    look_do = 1'b0;
    lvl_sel = first_lvl;
    unique case (req.kind)
      KIND_PUSH: begin
        push_ok = (int'(req.task_id) < TASKS) && (int'(req.priority_req) < LEVELS);
        lvl_sel = LVL_W'(req.priority_req);
      end
      KIND_POP, KIND_PEEK: begin
        look_do = any_busy;
      end
      default: begin
      end
    endcase
    head_sel  = head[lvl_sel];
    cnt_sel   = cnt[lvl_sel];
    push_full = push_ok && (cnt_sel == CNT_W'(TASKS));
    push_do   = push_ok && !push_full;
    pop_do    = look_do && (req.kind == KIND_POP);
  end

  // shared adder: tail slot on push, next head on pop
  assign add_b = (req.kind == KIND_PUSH) ? cnt_sel : CNT_W'(1);

  prq_mod_add u_add (
    .a   (head_sel),
    .b   (add_b),
    .sum (add_sum)
  );

  assign slot = (req.kind == KIND_PUSH) ? add_sum : head_sel;

  // store request
  always_comb begin
    mreq.we    = accept && push_do;
    mreq.re    = accept && look_do;
    mreq.addr  = ADDR_W'(lvl_sel) * ADDR_W'(TASKS) + ADDR_W'(slot);
    mreq.wdata = req.task_id[IDX_W-1:0];
  end

  prq_store u_store (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  // head and count update on the accept edge
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        head[l] <= '0;
        cnt[l]  <= '0;
      end
    end else if (accept) begin
      if (push_do) begin
        cnt[lvl_sel] <= cnt_sel + CNT_W'(1);
      end else if (pop_do) begin
        head[lvl_sel] <= add_sum;
        cnt[lvl_sel]  <= cnt_sel - CNT_W'(1);
      end
    end
  end

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      hit       <= 1'b0;
      ovf       <= 1'b0;
      empty_pop <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // pending response leaves on its handshake
          if (rsp.valid && rsp.ready) begin
            rsp.valid <= 1'b0;
          end
          if (accept) begin
            hit       <= look_do;
            ovf       <= push_full;
            empty_pop <= (req.kind == KIND_POP) && !any_busy;
            state     <= S_FINISH;
          end
        end
        S_FINISH: begin
          // a full register that is not taken simply holds
          if (rsp_free) begin
            rsp.valid       <= 1'b1;
            rsp.found       <= hit;
            rsp.overflow    <= ovf;
            rsp.result_task <= hit ? TID_W'(rd_data) :
                               (empty_pop ? TID_W'(TASKS) : '0);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_finish: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_FINISH))
    else $error("sequencer did not move to finish after accept");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_sel <= CNT_W'(TASKS))
    else $error("level count above ring size");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (accept && pop_do) |=> (cnt[$past(lvl_sel)] == $past(cnt_sel) - CNT_W'(1)))
    else $error("pop did not retire one entry");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.overflow))
    else $error("found and overflow both set");

  a_found_id: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> (rsp.result_task < TID_W'(TASKS)))
    else $error("found word carries idle or bad id");
`endif

endmodule

`default_nettype wire

// File: rtl/core/prq_mod_add.sv
// prq_mod_add: shared ring-pointer adder, (a + b) mod TASKS.
// Depends on prq_pkg; a < TASKS and b <= TASKS, so one conditional subtract wraps it.
`default_nettype none

module prq_mod_add
  import prq_pkg::*;
(
  input  wire logic [IDX_W-1:0] a,
  input  wire logic [CNT_W-1:0] b,
  output logic      [IDX_W-1:0] sum
);

  logic [SUM_W-1:0] raw;
  logic [SUM_W-1:0] wrapped;

  // add, then fold back once past the ring size
  always_comb begin
    raw     = SUM_W'(a) + SUM_W'(b);
    wrapped = (raw >= SUM_W'(TASKS)) ? (raw - SUM_W'(TASKS)) : raw;
    sum     = wrapped[IDX_W-1:0];
  end

endmodule

`default_nettype wire

// File: rtl/core/prq_store.sv
// prq_store: queue entry memory, one write and one registered read per cycle.
// Depends on prq_pkg for mem_req_t and sizes; contents are undefined after reset.
`default_nettype none

module prq_store
  import prq_pkg::*;
(
  input  wire logic             clk,
  input  wire mem_req_t         req,
  output logic      [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_priority_ready_queue_scheduler.sv
// tb_priority_ready_queue_scheduler: self-checking bench for the multilevel priority FIFO scheduler.
// Needs prq_pkg, prq_in_if, prq_out_if and the priority_ready_queue_scheduler RTL.
// Words are predicted at acceptance and the response stream is checked in order.
`default_nettype none

module tb_priority_ready_queue_scheduler;
  import prq_pkg::*;

  // Spare kind code: the block answers it with all fields zero
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int IDLE_ID     = TASKS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int CALM_TAIL   = 150;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  task_id;
    logic [PRI_W-1:0]  prio;
  } sched_req_t;

  typedef struct packed {
    logic [TID_W-1:0] task_id;
    logic             found;
    logic             overflow;
  } sched_rsp_t;

  logic clk;
  logic rst;

  prq_in_if  req_ch ();
  prq_out_if rsp_ch ();

  priority_ready_queue_scheduler uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Bench-side copy of the ready queues
  logic [IDX_W-1:0] lvl_ids   [LEVELS][TASKS];
  logic [IDX_W-1:0] lvl_head  [LEVELS];
  logic [CNT_W-1:0] lvl_count [LEVELS];

  sched_req_t pending_words [$];
  sched_rsp_t expected_rsp  [$];
  sched_req_t on_bus;

  int  errors      = 0;
  int  cycle_count = 0;
  int  send_gap    = 0;
  int  stall_left  = 0;
  int  idle_mode   = 0;
  logic calm       = 1'b0;

  // Apply one word to the queue copy and return the response it must produce
  function automatic sched_rsp_t schedule_word(input sched_req_t w);
    sched_rsp_t res;
    int busy;
    int lvl;
    int tail;
    logic [LVL_W-1:0] sel;
    res  = '0;
    busy = LEVELS;
    if (w.kind == KIND_PUSH) begin
      if (int'(w.task_id) < TASKS && int'(w.prio) < LEVELS) begin
        if (int'(lvl_count[w.prio]) >= TASKS) begin
          res.overflow = 1'b1;
        end else begin
          tail = (int'(lvl_head[w.prio]) + int'(lvl_count[w.prio])) % TASKS;
          lvl_ids[w.prio][IDX_W'(tail)] = w.task_id[IDX_W-1:0];
          lvl_count[w.prio] = lvl_count[w.prio] + 1'b1;
        end
      end
    end else if (w.kind == KIND_POP || w.kind == KIND_PEEK) begin
      for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
        if (lvl_count[LVL_W'(lvl)] != '0) busy = lvl;
      end
      if (busy < LEVELS) begin
        sel = LVL_W'(busy);
        res.task_id = TID_W'(lvl_ids[sel][lvl_head[sel]]);
        res.found   = 1'b1;
        if (w.kind == KIND_POP) begin
          lvl_head[sel]  = IDX_W'((int'(lvl_head[sel]) + 1) % TASKS);
          lvl_count[sel] = lvl_count[sel] - 1'b1;
        end
      end else if (w.kind == KIND_POP) begin
        res.task_id = TID_W'(IDLE_ID);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    errors++;
  endtask

  // Queue one word; returns 1 when the block actually acts on it
  function automatic int add_word(input int kind, input int tid, input int prio);
    sched_req_t w;
    w.kind    = KIND_W'(kind);
    w.task_id = TID_W'(tid);
    w.prio    = PRI_W'(prio);
    pending_words.push_back(w);
    if (w.kind == KIND_POP || w.kind == KIND_PEEK) return 1;
    if (w.kind == KIND_PUSH && tid < TASKS) return 1;
    return 0;
  endfunction

  // Clock, reset and known input levels from time zero
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.kind         = '0;
    req_ch.task_id      = '0;
    req_ch.priority_req = '0;
    rsp_ch.ready        = 1'b0;
    fork
      forever #5 clk = ~clk;
    join_none
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Cycle count, idle profile and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[7:0] == 8'd0) begin
      idle_mode <= $urandom_range(0, 2);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Request driver: predicts on accept, then presents the next pending word
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      lvl_head  = '{default: '0};
      lvl_count = '{default: '0};
    end else begin
      calm <= (pending_words.size() < CALM_TAIL);
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp.push_back(schedule_word(on_bus));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          on_bus = pending_words.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.kind         <= on_bus.kind;
          req_ch.task_id      <= on_bus.task_id;
          req_ch.priority_req <= on_bus.prio;
          if (!calm && idle_mode != 0 && $urandom_range(0, 9) < 2 * idle_mode - 1) begin
            send_gap = $urandom_range(1, 12);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back-pressure
  always @(posedge clk) begin
    sched_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response, result_task", rsp_ch.result_task, -1);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_ch.result_task !== want.task_id)
            report_mismatch("result_task", rsp_ch.result_task, want.task_id);
          if (rsp_ch.found !== want.found)
            report_mismatch("found", rsp_ch.found, want.found);
          if (rsp_ch.overflow !== want.overflow)
            report_mismatch("overflow", rsp_ch.overflow, want.overflow);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!calm && idle_mode != 0 && $urandom_range(0, 9) < 2 * idle_mode - 1) begin
          stall_left = $urandom_range(1, 12);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int acted;
    int i;
    int n;
    int lvl;
    int pick;
    int tid;
    acted = 0;

    // Directed: empty pop and peek, ignored pushes, spare kind, level extremes
    void'(add_word(KIND_POP, 0, 0));
    void'(add_word(KIND_PEEK, 0, 0));
    void'(add_word(KIND_PUSH, IDLE_ID, 0));
    void'(add_word(KIND_PUSH, 31, 2));
    void'(add_word(KIND_SPARE, 31, 7));
    void'(add_word(KIND_PUSH, 0, 7));
    // fill the top level completely, then push once more to overflow it
    for (i = 0; i < TASKS; i++) void'(add_word(KIND_PUSH, TASKS - 1 - i, 0));
    void'(add_word(KIND_PUSH, 9, 0));
    void'(add_word(KIND_PEEK, 0, 0));

    // Random segments: level fills, mixed traffic, drains and noise
    while (acted < 1500) begin
      case ($urandom_range(0, 3))
        0: begin
          lvl = $urandom_range(0, LEVELS - 1);
          n = $urandom_range(12, 20);
          for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
              acted += add_word($urandom_range(KIND_POP, KIND_PEEK), $urandom_range(0, 31),
                                $urandom_range(0, 7));
            else
              acted += add_word(KIND_PUSH, $urandom_range(0, TASKS - 1), lvl);
          end
        end
        1: begin
          lvl = $urandom_range(0, LEVELS - 1);
          for (i = 0; i < 40; i++) begin
            pick = $urandom_range(0, 99);
            tid  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                               : $urandom_range(0, TASKS - 1);
            if (pick < 55)
              acted += add_word(KIND_PUSH, tid, (lvl + $urandom_range(0, 2)) % LEVELS);
            else if (pick < 80)
              acted += add_word(KIND_POP, $urandom_range(0, 31), $urandom_range(0, 7));
            else if (pick < 95)
              acted += add_word(KIND_PEEK, $urandom_range(0, 31), $urandom_range(0, 7));
            else
              acted += add_word(KIND_SPARE, $urandom_range(0, 31), $urandom_range(0, 7));
          end
        end
        2: begin
          n = $urandom_range(10, 40);
          for (i = 0; i < n; i++) begin
            acted += add_word(($urandom_range(0, 4) == 0) ? KIND_PEEK : KIND_POP,
                              $urandom_range(0, 31), $urandom_range(0, 7));
          end
        end
        default: begin
          for (i = 0; i < 5; i++) begin
            acted += add_word($urandom_range(0, 3), $urandom_range(0, 31),
                              $urandom_range(0, 7));
          end
        end
      endcase
    end

    // Wait for the stream to drain, then allow time for stray responses
    @(negedge rst);
    while (pending_words.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
